>>> rtl/vertex_material_assign_defines.svh
// ----------------------------------------------------------------------------
// vertex_material_assign_defines
// assertion macros shared by the vertex material table block
// ----------------------------------------------------------------------------
`ifndef VERTEX_MATERIAL_ASSIGN_DEFINES_SVH
`define VERTEX_MATERIAL_ASSIGN_DEFINES_SVH

`ifndef NO_ASSERTIONS

// condition must never hold outside reset
`define VMA_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define VMA_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define VMA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define VMA_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`define VMA_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define VMA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

>>> rtl/vma_pkg.sv
// ----------------------------------------------------------------------------
// vma_pkg
// shared types and constants of the vertex material table block
// ----------------------------------------------------------------------------
package vma_pkg;

  // field widths of the stream beats
  localparam int unsigned VTX_W  = 16;
  localparam int unsigned MAT_W  = 16;
  localparam int unsigned CNT_W  = 17;
  localparam int unsigned CORNERS = 3;
  localparam int unsigned S_DATA_W = 64;
  localparam int unsigned M_DATA_W = 40;

  // item kinds carried on s_tuser
  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // vertex source select for memory read and entry update
  typedef enum logic [1:0] {
    SEL_A,
    SEL_B,
    SEL_C,
    SEL_PORT
  } vma_sel_t;

  // controller to datapath commands
  typedef struct packed {
    logic     accept;
    logic     rd_en;
    vma_sel_t rd_sel;
    logic     upd_en;
    vma_sel_t upd_sel;
    logic     clr_en;
    logic     res_load;
  } vma_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic out_free;
  } vma_sts_t;

endpackage

>>> rtl/vertex_material_assign.sv
// ----------------------------------------------------------------------------
// vertex_material_assign
// per-vertex material table built from triangles, with entry reads
// ----------------------------------------------------------------------------
//
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  s_tuser kind, s_tdata corners and material
// m_*      out  m_tvalid/m_tready  m_tdata one vertex entry, count and flag
//
// an add beat does one read-modify-write of the table per corner;
// the last corner write overlaps the first read of the next beat
// a read beat does a table read, then loads the result register
// after reset a clearing pass writes VERTEX_SLOTS entries, one per cycle,
// while s_tready stays low
// a full result register only holds a read beat in ST_READ, before its result load
//
module vertex_material_assign #(
  parameter int unsigned VERTEX_SLOTS  = 65536,
  parameter int unsigned MATERIAL_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // vertex_a, vertex_b, vertex_c, material
  input  logic [63:0] s_tdata,
  // kind
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // vertex_material, assigned, vertex_conflict, vertex_count, any_conflict
  output logic [39:0] m_tdata
);

  import vma_pkg::*;

  `include "vertex_material_assign_defines.svh"

  vma_cmd_t cmd;
  vma_sts_t sts;

  vma_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  vma_datapath #(
    .VERTEX_SLOTS  (VERTEX_SLOTS),
    .MATERIAL_BITS (MATERIAL_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .sts      (sts)
  );

  // checks
  `VMA_ASSERT_NEVER(a_clr_excl, clk, rst, cmd.clr_en && (cmd.upd_en || cmd.rd_en || s_tready), "clear overlaps table access")
  `VMA_ASSERT_IMPLY(a_res_free, clk, rst, cmd.res_load, sts.out_free, "result loaded into a full register")
  `VMA_ASSERT_NEXT(a_clr_done, clk, rst, cmd.clr_en && sts.clr_last, s_tready, "not ready after clearing pass")
  `VMA_ASSERT_NEXT(a_add_seq, clk, rst, cmd.accept && (s_tuser == KIND_ADD), cmd.upd_en && cmd.rd_en && (cmd.rd_sel == SEL_B), "corner sequence broken")

endmodule

>>> rtl/vma_ram.sv
// ----------------------------------------------------------------------------
// vma_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module vma_ram #(
  parameter int unsigned WIDTH = 18,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, old data on a same-address write, holds when idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/vma_ctrl.sv
// ----------------------------------------------------------------------------
// vma_ctrl
// sequencer for clearing pass, triangle corner updates and entry reads
// ----------------------------------------------------------------------------
module vma_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tuser,
  output logic              s_tready,
  output vma_pkg::vma_cmd_t cmd,
  input  vma_pkg::vma_sts_t sts
);

  import vma_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CORNER_B,
    ST_CORNER_C,
    ST_CORNER_W,
    ST_READ
  } state_t;

  state_t state;
  state_t state_next;

  // next state and commands
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    cmd        = '0;
    cmd.rd_sel  = SEL_PORT;
    cmd.upd_sel = SEL_A;
    case (state)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
        cmd.rd_en  = s_tvalid;
        if (s_tvalid) begin
          state_next = (s_tuser == KIND_READ) ? ST_READ : ST_CORNER_B;
        end
      end
      ST_CORNER_B: begin
        cmd.upd_en  = 1'b1;
        cmd.upd_sel = SEL_A;
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = SEL_B;
        state_next  = ST_CORNER_C;
      end
      ST_CORNER_C: begin
        cmd.upd_en  = 1'b1;
        cmd.upd_sel = SEL_B;
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = SEL_C;
        state_next  = ST_CORNER_W;
      end
      ST_CORNER_W: begin
        // last corner write overlaps the next beat's first read
        cmd.upd_en  = 1'b1;
        cmd.upd_sel = SEL_C;
        s_tready    = 1'b1;
        cmd.accept  = s_tvalid;
        cmd.rd_en   = s_tvalid;
        if (s_tvalid) begin
          state_next = (s_tuser == KIND_READ) ? ST_READ : ST_CORNER_B;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_READ: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/vma_datapath.sv
// ----------------------------------------------------------------------------
// vma_datapath
// vertex table memory, entry update, vertex count and result register
// ----------------------------------------------------------------------------
module vma_datapath #(
  parameter int unsigned VERTEX_SLOTS  = 65536,
  parameter int unsigned MATERIAL_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [vma_pkg::S_DATA_W-1:0]     s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [vma_pkg::M_DATA_W-1:0]     m_tdata,
  input  vma_pkg::vma_cmd_t                cmd,
  output vma_pkg::vma_sts_t                sts
);

  import vma_pkg::*;

  localparam int unsigned AW = $clog2(VERTEX_SLOTS);
  localparam int unsigned MW = MATERIAL_BITS;
  localparam int unsigned EW = MATERIAL_BITS + 2;

  // latched item
  logic [VTX_W-1:0] va;
  logic [VTX_W-1:0] vb;
  logic [VTX_W-1:0] vc;
  logic [MW-1:0]    mat;

  // memory ports
  logic          wr_en;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic [AW-1:0] raddr;
  logic [EW-1:0] rdata;

  // forwarding of the write issued alongside the last read
  logic          fwd_valid;
  logic [AW-1:0] fwd_addr;
  logic [EW-1:0] fwd_data;
  logic [AW-1:0] rd_addr_q;

  // clearing pass and global state
  logic [AW-1:0]    clr_addr;
  logic [CNT_W-1:0] highest;
  logic             conflict_seen;

  // result register
  logic [MAT_W-1:0] out_mat;
  logic             out_asg;
  logic             out_cf;
  logic [CNT_W-1:0] out_cnt;
  logic             out_any;

  logic [VTX_W-1:0] rd_vtx;
  logic [VTX_W-1:0] upd_vtx;
  logic             upd_in;
  logic             rd_in;
  logic [EW-1:0]    cur;
  logic [MW-1:0]    cur_mat;
  logic             cur_asg;
  logic             cur_cf;
  logic             differ;
  logic [MW-1:0]    new_mat;
  logic [CNT_W-1:0] upd_cnt;
  logic             upd_go;

  vma_ram #(
    .WIDTH (EW),
    .DEPTH (VERTEX_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      va  <= s_tdata[15:0];
      vb  <= s_tdata[31:16];
      vc  <= s_tdata[47:32];
      mat <= MW'(s_tdata[63:48]);
    end
  end

  // read address select
  always_comb begin
    case (cmd.rd_sel)
      SEL_A:    rd_vtx = va;
      SEL_B:    rd_vtx = vb;
      SEL_C:    rd_vtx = vc;
      SEL_PORT: rd_vtx = s_tdata[15:0];
      default:  rd_vtx = s_tdata[15:0];
    endcase
  end
  assign raddr = AW'(rd_vtx);

  // update vertex select
  always_comb begin
    case (cmd.upd_sel)
      SEL_A:   upd_vtx = va;
      SEL_B:   upd_vtx = vb;
      SEL_C:   upd_vtx = vc;
      default: upd_vtx = va;
    endcase
  end

  // current entry with bypass of a same-address write
  assign cur     = (fwd_valid && (fwd_addr == rd_addr_q)) ? fwd_data : rdata;
  assign cur_mat = cur[EW-1:2];
  assign cur_asg = cur[1];
  assign cur_cf  = cur[0];

  // entry merge: keep larger material, flag differing ones
  assign upd_in  = 32'(upd_vtx) < 32'(VERTEX_SLOTS);
  assign upd_go  = cmd.upd_en && upd_in;
  assign differ  = cur_asg && (cur_mat != mat);
  assign new_mat = (!cur_asg || (mat > cur_mat)) ? mat : cur_mat;
  assign upd_cnt = CNT_W'(upd_vtx) + CNT_W'(1);

  // memory write select, clearing pass writes zero entries
  assign wr_en = cmd.clr_en || upd_go;
  assign waddr = cmd.clr_en ? clr_addr : AW'(upd_vtx);
  assign wdata = cmd.clr_en ? '0 : {new_mat, 1'b1, cur_cf | differ};

  // bypass registers follow the read port
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (cmd.rd_en) begin
      fwd_valid <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      fwd_addr  <= waddr;
      fwd_data  <= wdata;
      rd_addr_q <= raddr;
    end
  end

  // clear address, vertex count and global conflict
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr      <= '0;
      highest       <= '0;
      conflict_seen <= 1'b0;
    end else begin
      if (cmd.clr_en) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (upd_go && (upd_cnt > highest)) begin
        highest <= upd_cnt;
      end
      if (upd_go && differ) begin
        conflict_seen <= 1'b1;
      end
    end
  end

  // result payload
  assign rd_in = 32'(va) < 32'(VERTEX_SLOTS);

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_mat <= rd_in ? MAT_W'(cur_mat) : '0;
      out_asg <= rd_in && cur_asg;
      out_cf  <= rd_in && cur_cf;
      out_cnt <= highest;
      out_any <= conflict_seen;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.res_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {4'b0000, out_any, out_cnt, out_cf, out_asg, out_mat};

  assign sts.clr_last = (clr_addr == AW'(VERTEX_SLOTS - 1));
  assign sts.out_free = !m_tvalid || m_tready;

endmodule

>>> tb/vma_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vma_table_checker
// watches both stream channels of the vertex material table. It keeps its own
// copy of the table, the vertex count and the conflict flag, and compares each
// result beat field by field with the oldest predicted entry.
// ----------------------------------------------------------------------------
module vma_table_checker
  import vma_pkg::*;
#(
  parameter int unsigned VERTEX_SLOTS  = 65536,
  parameter int unsigned MATERIAL_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tready,
  // vertex_a, vertex_b, vertex_c, material
  input  logic [S_DATA_W-1:0] s_tdata,
  // kind
  input  logic                s_tuser,
  input  logic                m_tvalid,
  input  logic                m_tready,
  // vertex_material, assigned, vertex_conflict, vertex_count, any_conflict
  input  logic [M_DATA_W-1:0] m_tdata,
  output int                  errors,
  output int                  pending
);

  // one vertex entry of the shadow table
  typedef struct packed {
    logic [31:0] mat;
    logic        hit;
    logic        clash;
  } slot_t;

  // result beat layout, last field in the lowest bits
  typedef struct packed {
    logic [M_DATA_W-37:0] pad;
    logic                 any_conflict;
    logic [CNT_W-1:0]     vertex_count;
    logic                 vertex_conflict;
    logic                 assigned;
    logic [MAT_W-1:0]     vertex_material;
  } entry_beat_t;

  slot_t            vtx_store [VERTEX_SLOTS];
  logic [CNT_W-1:0] vtx_count_q;
  logic             clash_any_q;
  entry_beat_t      expected_entries [$];

  // table starts out cleared, as after the clearing pass
  initial begin
    for (int i = 0; i < VERTEX_SLOTS; i++) vtx_store[i] = '0;
    vtx_count_q = '0;
    clash_any_q = 1'b0;
    errors      = 0;
    pending     = 0;
  end

  function automatic logic [31:0] mask_material(logic [MAT_W-1:0] raw);
    logic [63:0] mask;
    mask = (64'd1 << MATERIAL_BITS) - 64'd1;
    return 32'({48'd0, raw} & mask);
  endfunction

  // one corner of a triangle: keep the largest material, flag a clash
  task automatic mark_corner(logic [VTX_W-1:0] vtx, logic [31:0] mat);
    if (vtx >= VERTEX_SLOTS) return;
    if (vtx_store[vtx].hit) begin
      if (vtx_store[vtx].mat != mat) begin
        vtx_store[vtx].clash = 1'b1;
        clash_any_q          = 1'b1;
        if (mat > vtx_store[vtx].mat) vtx_store[vtx].mat = mat;
      end
    end else begin
      vtx_store[vtx].hit = 1'b1;
      vtx_store[vtx].mat = mat;
    end
    if ({1'b0, vtx} + 17'd1 > vtx_count_q) vtx_count_q = {1'b0, vtx} + 17'd1;
  endtask

  function automatic entry_beat_t lookup_entry(logic [VTX_W-1:0] vtx);
    entry_beat_t e;
    e = '0;
    if (vtx < VERTEX_SLOTS) begin
      e.vertex_material = vtx_store[vtx].mat[MAT_W-1:0];
      e.assigned        = vtx_store[vtx].hit;
      e.vertex_conflict = vtx_store[vtx].clash;
    end
    e.vertex_count = vtx_count_q;
    e.any_conflict = clash_any_q;
    return e;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t %s expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // result beats are checked before the input beat of the same edge
  always @(posedge clk) begin : watch
    entry_beat_t want;
    entry_beat_t got;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (expected_entries.size() == 0) begin
          $display("%0t result beat expected none actual %h", $time, m_tdata);
          errors++;
        end else begin
          want = expected_entries.pop_front();
          check_field("vertex_material", 64'(want.vertex_material),
                      64'(got.vertex_material));
          check_field("assigned", 64'(want.assigned), 64'(got.assigned));
          check_field("vertex_conflict", 64'(want.vertex_conflict),
                      64'(got.vertex_conflict));
          check_field("vertex_count", 64'(want.vertex_count), 64'(got.vertex_count));
          check_field("any_conflict", 64'(want.any_conflict), 64'(got.any_conflict));
          check_field("padding", 64'(want.pad), 64'(got.pad));
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == KIND_ADD) begin
          for (int c = 0; c < CORNERS; c++)
            mark_corner(s_tdata[c*VTX_W +: VTX_W],
                        mask_material(s_tdata[CORNERS*VTX_W +: MAT_W]));
        end else begin
          expected_entries = {expected_entries, lookup_entry(s_tdata[VTX_W-1:0])};
        end
      end
    end
    pending = expected_entries.size();
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives triangle and read beats into the vertex material table with random
// gaps and result back-pressure, including one long receiver hold-off, and
// reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_top;
  import vma_pkg::*;

  localparam int unsigned SLOTS = 65536;
  localparam int unsigned MBITS = 16;
  localparam int          ITEMS = 1150;
  localparam int          LIMIT = 1000000;
  localparam int          POOL  = 48;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;
  logic                s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [M_DATA_W-1:0] m_tdata;

  int          errors;
  int          pending;
  int          cycle_count = 0;
  bit          steady_in;
  logic [15:0] vtx_pool [POOL];
  logic [15:0] mat_pool [6];

  vertex_material_assign #(
    .VERTEX_SLOTS (SLOTS),
    .MATERIAL_BITS(MBITS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  vma_table_checker #(
    .VERTEX_SLOTS (SLOTS),
    .MATERIAL_BITS(MBITS)
  ) u_checker (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .errors  (errors),
    .pending (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit, covers the clearing pass and worst-case stalls
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("vertex_material_assign: mismatch");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] pick_vertex(int pool_pct);
    if ($urandom_range(0, 99) < pool_pct) return vtx_pool[$urandom_range(0, POOL-1)];
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [15:0] pick_material();
    if ($urandom_range(0, 1) == 0) return mat_pool[$urandom_range(0, 5)];
    return 16'($urandom_range(0, 65535));
  endfunction

  // offer one beat and hold it until accepted
  task automatic send_beat(logic kind, logic [15:0] va, logic [15:0] vb,
                           logic [15:0] vc, logic [15:0] mat);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {mat, vc, vb, va};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    gap = steady_in ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // result side: random stalls, then one long hold-off so the input backs up
  initial begin : receiver
    int gap;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst || !s_tready) @(posedge clk);
    for (int k = 0; ; k++) begin
      if (k == 60) begin
        m_tready <= 1'b0;
        repeat (500) @(posedge clk);
      end
      gap = ((k % 200) < 30) ? 0 : pick_gap();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // stimulus and verdict
  initial begin : stimulus
    logic [15:0] va;
    logic [15:0] vb;
    logic [15:0] vc;
    logic [15:0] mat;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= KIND_ADD;
    steady_in = 1'b0;
    for (int k = 0; k < POOL; k++)
      vtx_pool[k] = (k < 12) ? 16'(k) : 16'($urandom_range(0, 65535));
    vtx_pool[12] = 16'hFFFF;
    mat_pool[0] = 16'h0000;
    mat_pool[1] = 16'h0001;
    mat_pool[2] = 16'h00FF;
    mat_pool[3] = 16'h8000;
    mat_pool[4] = 16'hFFFF;
    mat_pool[5] = 16'($urandom_range(0, 65535));
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, repeated corners, smaller and larger materials
    send_beat(KIND_READ, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_beat(KIND_READ, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
    send_beat(KIND_ADD,  16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_beat(KIND_READ, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_beat(KIND_ADD,  16'h0005, 16'h0006, 16'h0007, 16'h1234);
    send_beat(KIND_ADD,  16'h0005, 16'h0005, 16'h0006, 16'h1234);
    send_beat(KIND_READ, 16'h0005, 16'h0000, 16'h0000, 16'h0000);
    send_beat(KIND_ADD,  16'h0006, 16'h0008, 16'h0009, 16'h0100);
    send_beat(KIND_READ, 16'h0006, 16'h0000, 16'h0000, 16'h0000);
    send_beat(KIND_ADD,  16'h0007, 16'h0009, 16'h0009, 16'hFFFF);
    send_beat(KIND_READ, 16'h0007, 16'h0000, 16'h0000, 16'h0000);
    send_beat(KIND_READ, 16'h0009, 16'h0000, 16'h0000, 16'h0000);
    send_beat(KIND_READ, 16'h0008, 16'h0000, 16'h0000, 16'h0000);
    send_beat(KIND_ADD,  16'hAAAA, 16'h5555, 16'h8000, 16'h5555);
    send_beat(KIND_READ, 16'hAAAA, 16'h0000, 16'h0000, 16'h0000);
    send_beat(KIND_READ, 16'h1234, 16'h0000, 16'h0000, 16'h0000);
    send_beat(KIND_ADD,  16'hFFFF, 16'h7FFF, 16'h0001, 16'hFFFF);
    send_beat(KIND_READ, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
    // a read ignores the other fields
    send_beat(KIND_READ, 16'h5555, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_beat(KIND_ADD,  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
    send_beat(KIND_READ, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
    send_beat(KIND_READ, 16'h0001, 16'h0000, 16'h0000, 16'h0000);

    // random: corners and reads mostly drawn from a small vertex pool
    for (int i = 0; i < ITEMS; i++) begin
      steady_in = (i % 256) < 40;
      if ($urandom_range(0, 99) < 60) begin
        va  = pick_vertex(80);
        vb  = ($urandom_range(0, 9) == 0) ? va : pick_vertex(80);
        vc  = ($urandom_range(0, 9) == 0) ? vb : pick_vertex(80);
        mat = pick_material();
        send_beat(KIND_ADD, va, vb, vc, mat);
        if ($urandom_range(0, 15) == 0)
          vtx_pool[$urandom_range(0, POOL-1)] = 16'($urandom_range(0, 65535));
      end else begin
        send_beat(KIND_READ, pick_vertex(85), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      end
    end
    s_tvalid <= 1'b0;

    // drain outstanding reads, then let the last add settle
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (16) @(posedge clk);
    if (errors == 0) begin
      $display("vertex_material_assign: match");
    end else begin
      $display("vertex_material_assign: mismatch");
    end
    $finish;
  end

endmodule
